/* rtl/lfd_pkg.sv */
// shared types and constants for the link frame deframer
`timescale 1ns / 1ps

package lfd_pkg;

    localparam int HEADER_BYTES = 5;

    localparam logic [8:0] COUNT_MAX = 9'd511;

    // security byte layout
    localparam int SEC_MODE_LSB  = 0;
    localparam int SEC_SEL_LSB   = 2;
    localparam int SEC_SIGNED    = 5;
    localparam int SEC_ENCRYPTED = 6;
    localparam int SEC_SIGNER    = 7;

    typedef enum logic [3:0] {
        FK_LENGTH  = 4'd0,
        FK_LLSEC   = 4'd1,
        FK_EPOCH   = 4'd2,
        FK_SEQNUM  = 4'd3,
        FK_DST     = 4'd4,
        FK_SIGNER  = 4'd5,
        FK_PAYLOAD = 4'd6,
        FK_MIC     = 4'd7,
        FK_DISCARD = 4'd8
    } field_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_ENCRYPTED = 2'd3
    } status_t;

    typedef struct packed {
        field_kind_t kind;
        logic [7:0]  data;
        logic [7:0]  index;
        logic        last;
        status_t     status;
        logic [1:0]  dst_mode;
        logic        signed_frame;
        logic [7:0]  epoch;
        logic [15:0] seq;
        logic [7:0]  body_len;
    } result_t;

    // destination address length by address mode
    function automatic logic [3:0] dst_len(input logic [1:0] mode);
        logic [3:0] len;
        begin
            unique case (mode)
                2'd1:    len = 4'd2;
                2'd2:    len = 4'd8;
                default: len = 4'd0;
            endcase
            return len;
        end
    endfunction

endpackage

/* rtl/link_frame_deframer_core.sv */
// link frame deframer: tags each frame byte with its field and checks the frame
//
//  channel | beat fields                                   | handshake
//  --------+-----------------------------------------------+-----------------------
//  input   | data_byte, frame_end                          | in_valid / in_stall
//  output  | field_kind, byte_out, field_index,            | out_valid / out_stall
//          | end_of_frame, status, addr_mode_out,          |
//          | signed_out, epoch_out, seq_out, payload_length|
//
// one beat in, one beat out; a new byte is taken every cycle while in_stall is low
// the result of a byte is registered in the output register, or in the skid entry while that holds a result
// an output register plus one skid entry decouple the two sides, so in_stall
// rises only when both hold results that have not been taken
// rst_n clears the frame state and empties both result slots
`timescale 1ns / 1ps

module link_frame_deframer_core #(
    parameter int MAX_FRAME_BYTES = 255,
    parameter int MAX_BODY_BYTES  = 254,
    parameter int SIGNATURE_BYTES = 48,
    parameter int SIGNER_ID_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  field_kind,
    output logic [7:0]  byte_out,
    output logic [7:0]  field_index,
    output logic        end_of_frame,
    output logic [1:0]  status,
    output logic [1:0]  addr_mode_out,
    output logic        signed_out,
    output logic [7:0]  epoch_out,
    output logic [15:0] seq_out,
    output logic [7:0]  payload_length
);

    import lfd_pkg::*;

    localparam logic [9:0] MAX_FRAME_C = 10'(MAX_FRAME_BYTES);
    localparam logic [9:0] MAX_BODY_C  = 10'(MAX_BODY_BYTES);
    localparam logic [9:0] SIG_C       = 10'(SIGNATURE_BYTES);
    localparam logic [9:0] SID_C       = 10'(SIGNER_ID_BYTES);
    localparam logic [9:0] HDR_C       = 10'(HEADER_BYTES);

    logic [8:0]  count_reg, count_next;
    logic [7:0]  dl_reg, dl_next;
    logic [1:0]  mode_reg, mode_next;
    logic        signed_reg, signed_next;
    status_t     err_reg, err_next;
    logic [7:0]  epoch_reg, epoch_next;
    logic [15:0] seq_reg, seq_next;

    result_t     out_reg, out_next;
    result_t     skid_reg, skid_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    result_t     res;
    logic        in_accept;
    logic        out_take;

    logic [9:0]  p10;
    logic [9:0]  dl10;
    logic [9:0]  dst_cur;
    logic [9:0]  fixed_cur;
    logic [9:0]  sig_cur;
    logic [9:0]  mic_start;
    logic [9:0]  need_new;
    logic [9:0]  bc10;
    logic [9:0]  dln10;
    logic [9:0]  used;
    logic [9:0]  diff;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;

    assign p10       = {1'b0, count_reg};
    assign dl10      = {2'b00, dl_reg};
    assign dst_cur   = {6'd0, dst_len(mode_reg)};
    assign sig_cur   = signed_reg ? SIG_C : 10'd0;
    assign fixed_cur = HDR_C + dst_cur + (signed_reg ? SID_C : 10'd0);
    assign mic_start = dl10 + 10'd1 - sig_cur;
    // header plus fields as the security byte now being taken declares them
    assign need_new  = HDR_C + {6'd0, dst_len(data_byte[SEC_MODE_LSB +: 2])}
                     + (data_byte[SEC_SIGNED] ? (SID_C + SIG_C) : 10'd0);

    always_comb
    begin
        count_next  = count_reg;
        dl_next     = dl_reg;
        mode_next   = mode_reg;
        signed_next = signed_reg;
        err_next    = err_reg;
        epoch_next  = epoch_reg;
        seq_next    = seq_reg;
        res         = '0;
        res.kind    = FK_DISCARD;
        res.data    = data_byte;
        res.index   = 8'd0;
        bc10        = 10'd0;
        dln10       = 10'd0;
        used        = 10'd0;
        diff        = 10'd0;

        if (err_reg == ST_OK && p10 < MAX_FRAME_C && (p10 == 10'd0 || p10 <= dl10))
        begin
            if (p10 == 10'd0)
            begin
                res.kind = FK_LENGTH;
                dl_next  = data_byte;
                if ({2'b00, data_byte} > MAX_BODY_C)
                    err_next = ST_TOO_LONG;
            end
            else if (p10 == 10'd1)
            begin
                res.kind    = FK_LLSEC;
                mode_next   = data_byte[SEC_MODE_LSB +: 2];
                signed_next = data_byte[SEC_SIGNED];
                if (data_byte[SEC_ENCRYPTED])
                    err_next = ST_ENCRYPTED;
                else if (data_byte[SEC_SEL_LSB +: 3] > 3'd1)
                    err_next = ST_INVALID;
                else if (data_byte[SEC_SIGNED] != data_byte[SEC_SIGNER])
                    err_next = ST_INVALID;
                else if (dl10 + 10'd1 < need_new)
                    err_next = ST_INVALID;
            end
            else if (p10 == 10'd2)
            begin
                res.kind   = FK_EPOCH;
                epoch_next = data_byte;
            end
            else if (p10 < HDR_C)
            begin
                res.kind  = FK_SEQNUM;
                res.index = 8'(p10 - 10'd3);
                seq_next  = {seq_reg[7:0], data_byte};
            end
            else if (p10 < HDR_C + dst_cur)
            begin
                res.kind  = FK_DST;
                res.index = 8'(p10 - HDR_C);
            end
            else if (p10 < fixed_cur)
            begin
                res.kind  = FK_SIGNER;
                res.index = 8'(p10 - HDR_C - dst_cur);
            end
            else if (signed_reg && p10 >= mic_start)
            begin
                res.kind  = FK_MIC;
                res.index = 8'(p10 - mic_start);
            end
            else
            begin
                res.kind  = FK_PAYLOAD;
                res.index = 8'(p10 - fixed_cur);
            end
        end

        // byte past the declared length or past the frame limit
        if (p10 != 10'd0 && p10 > dl10 && err_next == ST_OK)
            err_next = ST_INVALID;
        if (p10 >= MAX_FRAME_C && err_next == ST_OK)
            err_next = ST_TOO_LONG;

        if (count_reg != COUNT_MAX)
            count_next = count_reg + 9'd1;

        if (frame_end)
        begin
            res.last = 1'b1;
            bc10     = {1'b0, count_next};
            dln10    = {2'b00, dl_next};
            used     = HDR_C + {6'd0, dst_len(mode_next)}
                     + (signed_next ? (SID_C + SIG_C) : 10'd0);
            diff     = bc10 - used;
            if (bc10 > MAX_FRAME_C || dln10 > MAX_BODY_C)
                res.status = ST_TOO_LONG;
            else if (bc10 < HDR_C)
                res.status = ST_INVALID;
            else if (dln10 != bc10 - 10'd1)
                res.status = ST_INVALID;
            else
                res.status = err_next;

            if (res.status == ST_OK)
            begin
                res.dst_mode     = mode_next;
                res.signed_frame = signed_next;
                res.epoch        = epoch_next;
                res.seq          = seq_next;
                res.body_len     = (bc10 >= used) ? diff[7:0] : 8'd0;
            end

            count_next  = 9'd0;
            dl_next     = 8'd0;
            mode_next   = 2'd0;
            signed_next = 1'b0;
            err_next    = ST_OK;
            epoch_next  = 8'd0;
            seq_next    = 16'd0;
        end
    end

    // output register with one skid entry behind it
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= 9'd0;
            dl_reg         <= 8'd0;
            mode_reg       <= 2'd0;
            signed_reg     <= 1'b0;
            err_reg        <= ST_OK;
            epoch_reg      <= 8'd0;
            seq_reg        <= 16'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                count_reg  <= count_next;
                dl_reg     <= dl_next;
                mode_reg   <= mode_next;
                signed_reg <= signed_next;
                err_reg    <= err_next;
                epoch_reg  <= epoch_next;
                seq_reg    <= seq_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_valid_reg;
    assign field_kind     = out_reg.kind;
    assign byte_out       = out_reg.data;
    assign field_index    = out_reg.index;
    assign end_of_frame   = out_reg.last;
    assign status         = out_reg.status;
    assign addr_mode_out  = out_reg.dst_mode;
    assign signed_out     = out_reg.signed_frame;
    assign epoch_out      = out_reg.epoch;
    assign seq_out        = out_reg.seq;
    assign payload_length = out_reg.body_len;

    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // frame state restarts after the last byte
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && frame_end) |=> (count_reg == 9'd0 && err_reg == ST_OK))
        else $error("frame state not cleared after last beat");

    // a known error sticks until the frame ends
    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !frame_end && err_reg != ST_OK) |=> (err_reg != ST_OK))
        else $error("frame error dropped before end of frame");

    // header values only reported on a good frame
    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK)
            |-> (out_reg.seq == 16'd0 && out_reg.epoch == 8'd0
                 && out_reg.body_len == 8'd0))
        else $error("header values on a failed frame");

endmodule

/* verif/tb_top.sv */
// testbench for link_frame_deframer_core: directed frames, then random frames against a predictor
`timescale 1ns / 1ps

module tb_top;
    import lfd_pkg::*;

    localparam int FRAME_MAX    = 255;
    localparam int BODY_MAX     = 254;
    localparam int MIC_BYTES    = 48;
    localparam int SIGNER_BYTES = 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic        preset;
        field_kind_t kind;
        logic [7:0]  index;
        status_t     status;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  field_kind;
    logic [7:0]  byte_out;
    logic [7:0]  field_index;
    logic        end_of_frame;
    logic [1:0]  status;
    logic [1:0]  addr_mode_out;
    logic        signed_out;
    logic [7:0]  epoch_out;
    logic [15:0] seq_out;
    logic [7:0]  payload_length;

    // predictor copy of the frame state
    logic [8:0]  frm_count = 9'd0;
    logic [7:0]  frm_len = 8'd0;
    logic [1:0]  frm_mode = 2'd0;
    logic        frm_signed = 1'b0;
    status_t     frm_err = ST_OK;
    logic [7:0]  frm_epoch = 8'd0;
    logic [15:0] frm_seq = 16'd0;

    result_t     pending_tags[$];
    stim_row_t   stim_rows[$];
    logic [7:0]  frame_buf[$];

    int n_sent = 0;
    int n_frames = 0;
    int n_checked = 0;
    int n_bad = 0;
    int n_ends[4] = '{0, 0, 0, 0};
    logic send_busy = 1'b1;
    logic stall_busy = 1'b1;

    always #1 clk = ~clk;

    link_frame_deframer_core #(
        .MAX_FRAME_BYTES(FRAME_MAX),
        .MAX_BODY_BYTES (BODY_MAX),
        .SIGNATURE_BYTES(MIC_BYTES),
        .SIGNER_ID_BYTES(SIGNER_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .field_kind    (field_kind),
        .byte_out      (byte_out),
        .field_index   (field_index),
        .end_of_frame  (end_of_frame),
        .status        (status),
        .addr_mode_out (addr_mode_out),
        .signed_out    (signed_out),
        .epoch_out     (epoch_out),
        .seq_out       (seq_out),
        .payload_length(payload_length)
    );

    function automatic int addr_bytes(input logic [1:0] mode);
        int n;
        begin
            case (mode)
                2'd1:    n = 2;
                2'd2:    n = 8;
                default: n = 0;
            endcase
            return n;
        end
    endfunction

    // header, address and signer id bytes of the frame in progress
    function automatic int head_bytes();
        return HEADER_BYTES + addr_bytes(frm_mode) + (frm_signed ? SIGNER_BYTES : 0);
    endfunction

    function automatic int mic_bytes();
        return frm_signed ? MIC_BYTES : 0;
    endfunction

    function automatic int pause_len(input logic busy);
        return busy ? int'($urandom_range(8, 0)) : 0;
    endfunction

    function automatic string tag_text(input result_t r);
        return $sformatf({"kind=%0d byte=%h idx=%0d last=%b st=%0d mode=%0d sgn=%b",
                          " ep=%h seq=%h plen=%0d"},
                         r.kind, r.data, r.index, r.last, r.status, r.dst_mode,
                         r.signed_frame, r.epoch, r.seq, r.body_len);
    endfunction

    // tags one byte and advances the frame state
    task automatic tag_byte(input logic [7:0] b, input logic last, output result_t r);
        int p;
        int dl;
        int fix;
        int sig;
        int total;
        int cnt;
        status_t st;
        begin
            r = '0;
            r.kind = FK_DISCARD;
            r.data = b;
            p = int'(frm_count);
            if (frm_err == ST_OK && p < FRAME_MAX && (p < 1 || p <= frm_len)) begin
                if (p == 0) begin
                    r.kind = FK_LENGTH;
                    frm_len = b;
                    if (b > BODY_MAX)
                        frm_err = ST_TOO_LONG;
                end else if (p == 1) begin
                    r.kind = FK_LLSEC;
                    frm_mode = b[SEC_MODE_LSB +: 2];
                    frm_signed = b[SEC_SIGNED];
                    if (b[SEC_ENCRYPTED])
                        frm_err = ST_ENCRYPTED;
                    else if (b[SEC_SEL_LSB +: 3] > 3'd1)
                        frm_err = ST_INVALID;
                    else if (b[SEC_SIGNED] != b[SEC_SIGNER])
                        frm_err = ST_INVALID;
                    else if (frm_len + 1 < head_bytes() + mic_bytes())
                        frm_err = ST_INVALID;
                end else if (p == 2) begin
                    r.kind = FK_EPOCH;
                    frm_epoch = b;
                end else if (p < 5) begin
                    r.kind = FK_SEQNUM;
                    r.index = 8'(p - 3);
                    frm_seq = {frm_seq[7:0], b};
                end else begin
                    dl = addr_bytes(frm_mode);
                    fix = head_bytes();
                    sig = mic_bytes();
                    total = frm_len + 1;
                    if (p < 5 + dl) begin
                        r.kind = FK_DST;
                        r.index = 8'(p - 5);
                    end else if (p < fix) begin
                        r.kind = FK_SIGNER;
                        r.index = 8'(p - 5 - dl);
                    end else if (frm_signed && p >= total - sig) begin
                        r.kind = FK_MIC;
                        r.index = 8'(p - (total - sig));
                    end else begin
                        r.kind = FK_PAYLOAD;
                        r.index = 8'(p - fix);
                    end
                end
            end
            // a byte past the declared length or the frame limit
            if (p >= 1 && p > frm_len && frm_err == ST_OK)
                frm_err = ST_INVALID;
            if (p >= FRAME_MAX && frm_err == ST_OK)
                frm_err = ST_TOO_LONG;
            if (frm_count < COUNT_MAX)
                frm_count = frm_count + 9'd1;
            if (last) begin
                cnt = int'(frm_count);
                r.last = 1'b1;
                if (cnt > FRAME_MAX || frm_len > BODY_MAX)
                    st = ST_TOO_LONG;
                else if (cnt < HEADER_BYTES)
                    st = ST_INVALID;
                else if (frm_len != cnt - 1)
                    st = ST_INVALID;
                else
                    st = frm_err;
                r.status = st;
                if (st == ST_OK) begin
                    fix = head_bytes() + mic_bytes();
                    r.dst_mode = frm_mode;
                    r.signed_frame = frm_signed;
                    r.epoch = frm_epoch;
                    r.seq = frm_seq;
                    r.body_len = (cnt >= fix) ? 8'(cnt - fix) : 8'd0;
                end
                frm_count = 9'd0;
                frm_len = 8'd0;
                frm_mode = 2'd0;
                frm_signed = 1'b0;
                frm_err = ST_OK;
                frm_epoch = 8'd0;
                frm_seq = 16'd0;
            end
        end
    endtask

    // drives one beat; preset rows carry kind, index and status typed in by hand
    task automatic push_byte(input logic [7:0] b, input logic last, input logic preset,
                             input field_kind_t kind, input logic [7:0] index,
                             input status_t st);
        int gap;
        result_t r;
        begin
            gap = pause_len(send_busy);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= b;
            frame_end <= last;
            do
                @(posedge clk);
            while (in_stall);
            tag_byte(b, last, r);
            if (preset) begin
                r.kind = kind;
                r.index = index;
                r.status = st;
            end
            pending_tags.push_back(r);
            n_sent++;
            @(negedge clk);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic last, input logic preset,
                           input field_kind_t kind, input logic [7:0] index,
                           input status_t st);
        stim_row_t row;
        begin
            row.data = b;
            row.last = last;
            row.preset = preset;
            row.kind = kind;
            row.index = index;
            row.status = st;
            stim_rows.push_back(row);
        end
    endtask

    // fills frame_buf; raw_len > 0 gives a frame of raw_len random bytes
    task automatic build_frame(input int raw_len);
        int mode;
        int fix;
        int sig;
        int room;
        int plen;
        int total;
        int decl;
        int flaw;
        int i;
        logic sgn;
        logic sel0;
        logic [7:0] sec;
        logic [7:0] octet;
        begin
            frame_buf.delete();
            if (raw_len > 0) begin
                for (i = 0; i < raw_len; i++) begin
                    octet = 8'($urandom);
                    frame_buf.push_back(octet);
                end
            end else begin
                mode = $urandom_range(3, 0);
                sgn = ($urandom_range(3, 0) == 0);
                sel0 = 1'($urandom_range(1, 0));
                fix = HEADER_BYTES + addr_bytes(mode[1:0]) + (sgn ? SIGNER_BYTES : 0);
                sig = sgn ? MIC_BYTES : 0;
                room = FRAME_MAX - fix - sig;
                plen = ($urandom_range(7, 0) == 0) ? $urandom_range(room, 0)
                                                  : $urandom_range(12, 0);
                total = fix + plen + sig;
                decl = total - 1;
                sec = {sgn, 1'b0, sgn, 2'b00, sel0, mode[1:0]};
                flaw = ($urandom_range(9, 0) < 3) ? int'($urandom_range(7, 0)) : -1;
                case (flaw)
                    0: sec[SEC_ENCRYPTED] = 1'b1;
                    1: sec[SEC_SEL_LSB +: 3] = 3'($urandom_range(7, 2));
                    2: begin
                        if ($urandom_range(1, 0))
                            sec[SEC_SIGNED] = ~sec[SEC_SIGNED];
                        else
                            sec[SEC_SIGNER] = ~sec[SEC_SIGNER];
                    end
                    3: decl = $urandom_range(255, 0);
                    4: decl = $urandom_range(1, 0) ? decl + 1 : decl - 1;
                    7: begin
                        // declared length too short for the fields, frame cut to match
                        if (fix + sig - 2 >= 4)
                            decl = $urandom_range(fix + sig - 2, 4);
                    end
                    default: ;
                endcase
                octet = 8'(decl);
                frame_buf.push_back(octet);
                frame_buf.push_back(sec);
                for (i = 2; i < total; i++) begin
                    octet = 8'($urandom);
                    frame_buf.push_back(octet);
                end
                if (flaw == 5) begin
                    repeat ($urandom_range(frame_buf.size() - 1, 1))
                        frame_buf.pop_back();
                end else if (flaw == 6) begin
                    repeat ($urandom_range(5, 1)) begin
                        octet = 8'($urandom);
                        frame_buf.push_back(octet);
                    end
                end else if (flaw == 7) begin
                    while (frame_buf.size() > decl + 1)
                        frame_buf.pop_back();
                end
            end
        end
    endtask

    task automatic check_beat();
        result_t got;
        result_t want;
        logic bad;
        begin
            got.kind = field_kind_t'(field_kind);
            got.data = byte_out;
            got.index = field_index;
            got.last = end_of_frame;
            got.status = status_t'(status);
            got.dst_mode = addr_mode_out;
            got.signed_frame = signed_out;
            got.epoch = epoch_out;
            got.seq = seq_out;
            got.body_len = payload_length;
            if (end_of_frame === 1'b1)
                n_ends[status]++;
            if (pending_tags.size() == 0) begin
                n_bad++;
                if (n_bad <= REPORT_MAX)
                    $display("unexpected beat: %s", tag_text(got));
            end else begin
                want = pending_tags.pop_front();
                n_checked++;
                bad = (got.kind !== want.kind) || (got.data !== want.data) ||
                      (got.index !== want.index) || (got.last !== want.last) ||
                      (got.status !== want.status) || (got.dst_mode !== want.dst_mode) ||
                      (got.signed_frame !== want.signed_frame) ||
                      (got.epoch !== want.epoch) || (got.seq !== want.seq) ||
                      (got.body_len !== want.body_len);
                if (bad) begin
                    n_bad++;
                    if (n_bad <= REPORT_MAX) begin
                        $display("mismatch on beat %0d", n_checked);
                        $display("  expected %s", tag_text(want));
                        $display("  actual   %s", tag_text(got));
                    end
                end
            end
        end
    endtask

    // receiver: random stall before each beat, stretches with none
    initial begin
        int k;
        int since;
        since = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (since == 50) begin
                since = 0;
                stall_busy = ($urandom_range(3, 0) != 0);
            end
            k = pause_len(stall_busy);
            if (k > 0) begin
                out_stall <= 1'b1;
                repeat (k) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            check_beat();
            since++;
            @(negedge clk);
        end
    end

    initial begin
        #1000000;
        $display("timeout: run did not finish");
        $display("FAILURE");
        $finish;
    end

    initial begin
        int i;
        int rand_frames;
        int drain;
        stim_row_t row;

        // declared length above the body limit
        add_row(8'hff, 1'b1, 1'b1, FK_LENGTH, 8'd0, ST_TOO_LONG);
        // zero length: second byte lies past it, frame shorter than the header
        add_row(8'h00, 1'b0, 1'b1, FK_LENGTH, 8'd0, ST_OK);
        add_row(8'h00, 1'b1, 1'b1, FK_DISCARD, 8'd0, ST_INVALID);
        // encrypted
        add_row(8'h04, 1'b0, 1'b1, FK_LENGTH, 8'd0, ST_OK);
        add_row(8'h40, 1'b0, 1'b1, FK_LLSEC, 8'd0, ST_OK);
        add_row(8'h00, 1'b0, 1'b1, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'h00, 1'b0, 1'b1, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'h00, 1'b1, 1'b1, FK_DISCARD, 8'd0, ST_ENCRYPTED);
        // selector out of range, short frame
        add_row(8'h02, 1'b0, 1'b1, FK_LENGTH, 8'd0, ST_OK);
        add_row(8'h0c, 1'b0, 1'b1, FK_LLSEC, 8'd0, ST_OK);
        add_row(8'h00, 1'b1, 1'b1, FK_DISCARD, 8'd0, ST_INVALID);
        // minimal good frame, all-ones header values
        add_row(8'h04, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'h00, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'hff, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'hff, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'hff, 1'b1, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        // short address, one payload byte
        add_row(8'h07, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'h01, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'h5a, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'h12, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'h34, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'haa, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'hbb, 1'b0, 1'b0, FK_DISCARD, 8'd0, ST_OK);
        add_row(8'hcc, 1'b1, 1'b0, FK_DISCARD, 8'd0, ST_OK);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < stim_rows.size(); i++) begin
            row = stim_rows[i];
            push_byte(row.data, row.last, row.preset, row.kind, row.index, row.status);
            if (row.last)
                n_frames++;
        end

        rand_frames = 0;
        while (n_sent < stim_rows.size() + RANDOM_ITEMS) begin
            // early oversized frames: past the frame limit, then past counter saturation
            if (rand_frames == 0)
                build_frame(300);
            else if (rand_frames == 1)
                build_frame(520);
            else if ($urandom_range(59, 0) == 0)
                build_frame($urandom_range(270, 250));
            else
                build_frame(0);
            send_busy = ($urandom_range(3, 0) != 0);
            for (i = 0; i < frame_buf.size(); i++)
                push_byte(frame_buf[i], i == frame_buf.size() - 1, 1'b0, FK_DISCARD, 8'd0,
                          ST_OK);
            rand_frames++;
            n_frames++;
        end
        in_valid <= 1'b0;

        drain = 0;
        while (pending_tags.size() != 0 && drain < 5000) begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (pending_tags.size() != 0) begin
            n_bad++;
            $display("%0d results never arrived", pending_tags.size());
        end

        $display("%0d frames, %0d bytes sent, %0d beats checked, %0d errors",
                 n_frames, n_sent, n_checked, n_bad);
        $display("frame ends ok/invalid/too long/encrypted: %0d/%0d/%0d/%0d",
                 n_ends[0], n_ends[1], n_ends[2], n_ends[3]);
        if (n_bad == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
